FILE: design/sfd_pkg.sv
// Package for the servo frame decoder: frame constants, config register
// indexes and the payload types shared by the core.
// No dependencies.
`timescale 1ns / 1ps

package sfd_pkg;

  // Frame format
  localparam logic [7:0] HEADER_BYTE = 8'hFF;
  localparam int         DATA_BYTES  = 6;
  localparam int         HIGH_SHIFT  = 7;
  localparam int         SCALE_SHIFT = 14;

  // Widths
  localparam int BYTE_W = 8;
  localparam int CMD_W  = BYTE_W + HIGH_SHIFT;   // joint command, 15 bits
  localparam int REG_W  = 16;                    // gain and offset registers
  localparam int PROD_W = CMD_W + REG_W;         // command * gain
  localparam int POS_W  = 18;                    // scaled position
  localparam int POS_W_PAD = 56;                 // three positions, byte aligned
  localparam int FPOS_W = 3;                     // frame position counter
  localparam int CFG_IDX_W = 3;

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SHOULDER_GAIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ELBOW_GAIN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EFFECTOR_GAIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOULDER_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ELBOW_OFFSET    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_EFFECTOR_OFFSET = 3'd5;

  // Reset values of the config registers
  localparam logic [REG_W-1:0] SHOULDER_GAIN_RST   = 16'd4100;
  localparam logic [REG_W-1:0] ELBOW_GAIN_RST      = 16'd3700;
  localparam logic [REG_W-1:0] EFFECTOR_GAIN_RST   = 16'd3700;
  localparam logic [REG_W-1:0] SHOULDER_OFFSET_RST = 16'd1000;
  localparam logic [REG_W-1:0] ELBOW_OFFSET_RST    = 16'd500;
  localparam logic [REG_W-1:0] EFFECTOR_OFFSET_RST = 16'd1000;

  // Frame position codes
  localparam logic [FPOS_W-1:0] FPOS_HUNT = 3'd0;
  localparam logic [FPOS_W-1:0] FPOS_LAST = 3'd6;

  typedef logic [CMD_W-1:0]  cmd_t;
  typedef logic [PROD_W-1:0] prod_t;
  typedef logic [POS_W-1:0]  pos_t;

  // Joint command from a low/high byte pair; the bytes overlap in bit 7
  function automatic cmd_t make_cmd(input logic [BYTE_W-1:0] low,
                                    input logic [BYTE_W-1:0] high);
    make_cmd = {high, {HIGH_SHIFT{1'b0}}} | {{HIGH_SHIFT{1'b0}}, low};
  endfunction

endpackage

FILE: design/servo_frame_decoder_core.sv
// Servo frame decoder core: header hunt, data byte capture and a three-stage
// scaling pipeline for shoulder, elbow and end effector positions.
// Depends on sfd_pkg.
`timescale 1ns / 1ps

// Channel  | Dir | Signals                      | Word
// ---------+-----+------------------------------+------------------------------
// in       | in  | in_tvalid/in_tready/in_tdata | [7:0] rx_byte
// out      | out | out_tvalid/out_tready/...    | [17:0] shoulder_position,
//          |     |                              | [35:18] elbow, [53:36] effector
// cfg      | in  | cfg_wr_en/cfg_index/cfg_data | 16-bit register write
//
// One byte is taken every cycle while the pipeline has room. The sixth data
// byte of a frame enters three stages (command, multiply, scale and add), and
// its result is registered in each in turn before it shows on out_tvalid.
// Reset (synchronous, active low) returns to header hunting and loads the
// register defaults. A stalled output holds its word; in_tready drops only
// when all three stages hold words.

module servo_frame_decoder_core
  import sfd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [BYTE_W-1:0]     in_tdata,   // [7:0] rx_byte
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [POS_W_PAD-1:0]  out_tdata,  // [17:0] shoulder_position,
                                            // [35:18] elbow_position,
                                            // [53:36] effector_position, zero pad
  // config writes
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [REG_W-1:0]      cfg_data
);

  localparam int STORE_D = DATA_BYTES - 1;

  // Config registers
  logic [REG_W-1:0] gain_r [3];
  logic [REG_W-1:0] offset_r [3];

  // Frame state
  logic [FPOS_W-1:0] fpos_r, fpos_nxt;
  logic [BYTE_W-1:0] store_r [STORE_D];

  // Pipeline
  logic  s1_valid_r, s2_valid_r, out_valid_r;
  cmd_t  cmd_r [3];
  prod_t prod_r [3];
  pos_t  pos_r [3];

  logic in_acc, fire, s1_ready, s2_ready, out_ready;

  // Config register writes; indexes beyond the list are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r[0]   <= SHOULDER_GAIN_RST;
      gain_r[1]   <= ELBOW_GAIN_RST;
      gain_r[2]   <= EFFECTOR_GAIN_RST;
      offset_r[0] <= SHOULDER_OFFSET_RST;
      offset_r[1] <= ELBOW_OFFSET_RST;
      offset_r[2] <= EFFECTOR_OFFSET_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SHOULDER_GAIN:   gain_r[0]   <= cfg_data;
        CFG_ELBOW_GAIN:      gain_r[1]   <= cfg_data;
        CFG_EFFECTOR_GAIN:   gain_r[2]   <= cfg_data;
        CFG_SHOULDER_OFFSET: offset_r[0] <= cfg_data;
        CFG_ELBOW_OFFSET:    offset_r[1] <= cfg_data;
        CFG_EFFECTOR_OFFSET: offset_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake and stage advance
  assign out_ready = !out_valid_r || out_tready;
  assign s2_ready  = !s2_valid_r || out_ready;
  assign s1_ready  = !s1_valid_r || s2_ready;
  assign in_tready = s1_ready;
  assign in_acc    = in_tvalid && in_tready;
  assign fire      = in_acc && (fpos_r == FPOS_LAST);

  // Frame position: hunt for header, then count six data bytes
  always_comb begin
    fpos_nxt = fpos_r;
    if (in_acc) begin
      if (fpos_r == FPOS_HUNT) begin
        if (in_tdata == HEADER_BYTE) fpos_nxt = FPOS_W'(1);
      end else if (fpos_r >= FPOS_LAST) begin
        fpos_nxt = FPOS_HUNT;
      end else begin
        fpos_nxt = fpos_r + FPOS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) fpos_r <= FPOS_HUNT;
    else        fpos_r <= fpos_nxt;
  end

  // Data bytes one to five; the sixth goes straight into the command stage
  always_ff @(posedge clk) begin
    if (in_acc && fpos_r != FPOS_HUNT && fpos_r < FPOS_LAST)
      store_r[FPOS_W'(fpos_r - FPOS_W'(1))] <= in_tdata;
  end

  // Stage 1: joint commands
  always_ff @(posedge clk) begin
    if (!rst_n)        s1_valid_r <= 1'b0;
    else if (s1_ready) s1_valid_r <= fire;
  end

  always_ff @(posedge clk) begin
    if (s1_ready && fire) begin
      cmd_r[0] <= make_cmd(store_r[0], store_r[1]);
      cmd_r[1] <= make_cmd(store_r[2], store_r[3]);
      cmd_r[2] <= make_cmd(store_r[4], in_tdata);
    end
  end

  // Stage 2: command * gain, one multiplier per joint
  always_ff @(posedge clk) begin
    if (!rst_n)        s2_valid_r <= 1'b0;
    else if (s2_ready) s2_valid_r <= s1_valid_r;
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid_r) begin
      for (int j = 0; j < 3; j++)
        prod_r[j] <= PROD_W'(cmd_r[j]) * PROD_W'(gain_r[j]);
    end
  end

  // Stage 3: drop the scale bits and add the offset
  always_ff @(posedge clk) begin
    if (!rst_n)         out_valid_r <= 1'b0;
    else if (out_ready) out_valid_r <= s2_valid_r;
  end

  always_ff @(posedge clk) begin
    if (out_ready && s2_valid_r) begin
      for (int j = 0; j < 3; j++)
        pos_r[j] <= POS_W'(prod_r[j][PROD_W-1:SCALE_SHIFT]) + POS_W'(offset_r[j]);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(POS_W_PAD - 3*POS_W){1'b0}}, pos_r[2], pos_r[1], pos_r[0]};

`ifndef SYNTHESIS
  // Frame position never leaves the hunt..last range
  a_fpos_range: assert property (@(posedge clk) disable iff (!rst_n)
    fpos_r <= FPOS_LAST)
    else $error("frame position out of range");

  // The last data byte always launches a word into the command stage
  a_fire_load: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> s1_valid_r)
    else $error("last data byte did not load the command stage");

  // A non-header byte while hunting keeps the decoder hunting
  a_hunt_stay: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && fpos_r == FPOS_HUNT && in_tdata != HEADER_BYTE) |=> fpos_r == FPOS_HUNT)
    else $error("left hunting without a header");

  // An empty pipeline always takes input
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!s1_valid_r && !s2_valid_r && !out_valid_r) |-> in_tready)
    else $error("empty pipeline refused input");
`endif

endmodule

FILE: tb/servo_frame_decoder_core_tb.sv
// Self-checking bench for servo_frame_decoder_core: byte stream in, three joint
// positions out, scored against a bit-true position predictor in this file.
// Depends on sfd_pkg and the core RTL.
`timescale 1ns / 1ps

module servo_frame_decoder_core_tb;
  import sfd_pkg::*;

  localparam int          CYCLE_LIMIT   = 200000;
  localparam int          SETTLE_CYCLES = 8;      // pipeline is three stages deep
  localparam int          CHUNKS        = 4;
  localparam int          CHUNK_BYTES   = 85;
  localparam logic [REG_W-1:0] REG_MAX  = 16'hFFFF;
  localparam logic [REG_W-1:0] REG_ZERO = 16'h0000;
  // Register indexes past the last register; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  // Joint slots in the gain/offset mirrors
  localparam int SHOULDER = 0;
  localparam int ELBOW    = 1;
  localparam int EFFECTOR = 2;

  typedef struct packed {
    pos_t effector;
    pos_t elbow;
    pos_t shoulder;
  } joint_positions_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [BYTE_W-1:0]    in_tdata   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [POS_W_PAD-1:0] out_tdata;
  logic                 cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [REG_W-1:0]     cfg_data   = '0;

  // Stimulus and scoreboard
  logic [BYTE_W-1:0]    pending_bytes[$];
  joint_positions_t     expected_positions[$];
  logic                 in_word_taken = 1'b0;
  int unsigned          send_idle_pct  = 0;
  int unsigned          recv_stall_pct = 0;
  int unsigned          error_count    = 0;
  int unsigned          cycle_count    = 0;

  // Predictor state: mirrored registers and frame capture
  logic [REG_W-1:0]     joint_gain[3];
  logic [REG_W-1:0]     joint_offset[3];
  logic [FPOS_W-1:0]    frame_pos;
  logic [BYTE_W-1:0]    frame_bytes[DATA_BYTES];

  servo_frame_decoder_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // Scaled position of one joint from its low/high byte pair
  function automatic pos_t joint_position(input logic [BYTE_W-1:0] low,
                                          input logic [BYTE_W-1:0] high,
                                          input logic [REG_W-1:0]  gain,
                                          input logic [REG_W-1:0]  offset);
    logic [CMD_W-1:0]  command;
    logic [PROD_W-1:0] product;
    command = {high, {HIGH_SHIFT{1'b0}}} | CMD_W'(low);   // bit 7 overlaps
    product = PROD_W'(command) * PROD_W'(gain);
    return pos_t'(product >> SCALE_SHIFT) + pos_t'(offset);
  endfunction

  // Frame tracking for one accepted byte; the sixth data byte yields a result
  task automatic track_frame_byte(input logic [BYTE_W-1:0] rx);
    joint_positions_t positions;
    if (frame_pos == FPOS_HUNT) begin
      if (rx == HEADER_BYTE) frame_pos = FPOS_HUNT + 1'b1;
    end else if (frame_pos > FPOS_LAST) begin
      frame_pos = FPOS_HUNT;
    end else begin
      frame_bytes[frame_pos - 1] = rx;
      if (frame_pos < FPOS_LAST) begin
        frame_pos = frame_pos + 1'b1;
      end else begin
        frame_pos = FPOS_HUNT;
        positions.shoulder = joint_position(frame_bytes[0], frame_bytes[1],
                                            joint_gain[SHOULDER], joint_offset[SHOULDER]);
        positions.elbow    = joint_position(frame_bytes[2], frame_bytes[3],
                                            joint_gain[ELBOW], joint_offset[ELBOW]);
        positions.effector = joint_position(frame_bytes[4], frame_bytes[5],
                                            joint_gain[EFFECTOR], joint_offset[EFFECTOR]);
        expected_positions.push_back(positions);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [POS_W-1:0] exp_val,
                             input logic [POS_W-1:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, act_val);
      error_count++;
    end
  endtask

  // Monitor: mirror register writes, predict on accepted bytes, score results
  always @(posedge clk) begin
    joint_positions_t exp_pos;
    in_word_taken <= in_tvalid && in_tready;
    if (!rst_n) begin
      joint_gain[SHOULDER]   = SHOULDER_GAIN_RST;
      joint_gain[ELBOW]      = ELBOW_GAIN_RST;
      joint_gain[EFFECTOR]   = EFFECTOR_GAIN_RST;
      joint_offset[SHOULDER] = SHOULDER_OFFSET_RST;
      joint_offset[ELBOW]    = ELBOW_OFFSET_RST;
      joint_offset[EFFECTOR] = EFFECTOR_OFFSET_RST;
      frame_pos              = FPOS_HUNT;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_SHOULDER_GAIN:   joint_gain[SHOULDER]   = cfg_data;
          CFG_ELBOW_GAIN:      joint_gain[ELBOW]      = cfg_data;
          CFG_EFFECTOR_GAIN:   joint_gain[EFFECTOR]   = cfg_data;
          CFG_SHOULDER_OFFSET: joint_offset[SHOULDER] = cfg_data;
          CFG_ELBOW_OFFSET:    joint_offset[ELBOW]    = cfg_data;
          CFG_EFFECTOR_OFFSET: joint_offset[EFFECTOR] = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) track_frame_byte(in_tdata);
      if (out_tvalid && out_tready) begin
        if (expected_positions.size() == 0) begin
          $display("%0t: unexpected result word, expected none, got %h", $time, out_tdata);
          error_count++;
        end else begin
          exp_pos = expected_positions.pop_front();
          check_field("shoulder_position", exp_pos.shoulder, out_tdata[POS_W-1:0]);
          check_field("elbow_position", exp_pos.elbow, out_tdata[2*POS_W-1:POS_W]);
          check_field("effector_position", exp_pos.effector,
                      out_tdata[3*POS_W-1:2*POS_W]);
          if (out_tdata[POS_W_PAD-1:3*POS_W] !== '0) begin
            $display("%0t: pad bits mismatch, expected 0, got %h", $time,
                     out_tdata[POS_W_PAD-1:3*POS_W]);
            error_count++;
          end
        end
      end
    end
  end

  // Byte driver: holds a word until taken, idles at random between words
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_word_taken) begin
      if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata  <= pending_bytes.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result sink backpressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [REG_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic write_all_registers(input logic [REG_W-1:0] gain_val,
                                     input logic [REG_W-1:0] offset_val);
    write_register(CFG_SHOULDER_GAIN, gain_val);
    write_register(CFG_ELBOW_GAIN, gain_val);
    write_register(CFG_EFFECTOR_GAIN, gain_val);
    write_register(CFG_SHOULDER_OFFSET, offset_val);
    write_register(CFG_ELBOW_OFFSET, offset_val);
    write_register(CFG_EFFECTOR_OFFSET, offset_val);
  endtask

  // Wait until every byte is taken and every result scored, then let the pipe empty;
  // checked at the rising edge, where the driver's queue and in_tvalid are steady
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_bytes.size() != 0 || in_tvalid || expected_positions.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [REG_W-1:0] random_register();
    case ($urandom_range(5))
      0:       return REG_ZERO;
      1:       return REG_MAX;
      default: return REG_W'($urandom);
    endcase
  endfunction

  // Data bytes lean on 0xFF, zero and the bit-7 boundary
  function automatic logic [BYTE_W-1:0] random_data_byte();
    case ($urandom_range(7))
      0:       return HEADER_BYTE;
      1:       return 8'h00;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return BYTE_W'($urandom);
    endcase
  endfunction

  task automatic queue_frame(input logic [BYTE_W-1:0] b0, input logic [BYTE_W-1:0] b1,
                             input logic [BYTE_W-1:0] b2, input logic [BYTE_W-1:0] b3,
                             input logic [BYTE_W-1:0] b4, input logic [BYTE_W-1:0] b5);
    pending_bytes.push_back(HEADER_BYTE);
    pending_bytes.push_back(b0);
    pending_bytes.push_back(b1);
    pending_bytes.push_back(b2);
    pending_bytes.push_back(b3);
    pending_bytes.push_back(b4);
    pending_bytes.push_back(b5);
  endtask

  // Mostly clean frames with random content, some line noise and cut-off frames
  task automatic queue_random_bytes(input int count);
    int added;
    int kind;
    int len;
    added = 0;
    while (added < count) begin
      kind = $urandom_range(9);
      if (kind == 0) begin
        pending_bytes.push_back(BYTE_W'($urandom));
        added++;
      end else if (kind == 1) begin
        // truncated frame: the next header is swallowed as data
        len = $urandom_range(5, 1);
        pending_bytes.push_back(HEADER_BYTE);
        repeat (len) pending_bytes.push_back(random_data_byte());
        added += len + 1;
      end else begin
        len = $urandom_range(2);
        repeat (len) pending_bytes.push_back(BYTE_W'($urandom_range(HEADER_BYTE - 1)));
        queue_frame(random_data_byte(), random_data_byte(), random_data_byte(),
                    random_data_byte(), random_data_byte(), random_data_byte());
        added += len + 7;
      end
    end
  endtask

  // Run ceiling
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("** servo_frame_decoder_core: FAILED **");
    $finish;
  end

  // Test sequence
  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // Reset defaults: hunting noise, all-0xFF frame, zero frame, bit-7 overlap frame
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(8'hFE);
    pending_bytes.push_back(8'h7F);
    queue_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    queue_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_frame(8'h80, 8'h01, 8'h7F, 8'h80, 8'h55, 8'hAA);
    wait_drained();

    // Largest gains and offsets, plus writes past the register list
    write_all_registers(REG_MAX, REG_MAX);
    write_register(CFG_SPARE_LO, REG_W'($urandom));
    write_register(CFG_SPARE_HI, REG_W'($urandom));
    queue_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    queue_frame(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    wait_drained();

    // Zero gains and offsets
    write_all_registers(REG_ZERO, REG_ZERO);
    write_register(CFG_SPARE_HI, REG_MAX);
    queue_frame(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    queue_frame(8'h01, 8'h00, 8'h80, 8'h7F, 8'hAA, 8'h55);
    wait_drained();

    // Random traffic under each flow-control mix, fresh registers per mix
    for (int mix = 0; mix < 4; mix++) begin
      case (mix)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      write_register(CFG_SHOULDER_GAIN, random_register());
      write_register(CFG_ELBOW_GAIN, random_register());
      write_register(CFG_EFFECTOR_GAIN, random_register());
      write_register(CFG_SHOULDER_OFFSET, random_register());
      write_register(CFG_ELBOW_OFFSET, random_register());
      write_register(CFG_EFFECTOR_OFFSET, random_register());
      for (int chunk = 0; chunk < CHUNKS; chunk++) begin
        queue_random_bytes(CHUNK_BYTES);
        wait_drained();
      end
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("** servo_frame_decoder_core: PASSED **");
    end else begin
      $display("** servo_frame_decoder_core: FAILED **");
    end
    $finish;
  end

endmodule
